@@ rtl/dsl_pkg.sv @@
// Shared types, codes and keyword tables of the DSL byte lexer.
package dsl_pkg;

   localparam int OFFSET_BITS_DEFAULT = 16;
   localparam int KEYWORD_COUNT       = 6;
   localparam int KW_TABLE            = 6;
   localparam int KW_MAX_LEN          = 8;
   localparam int RSP_DEPTH           = 4;

   // Token kinds.
   localparam logic [4:0] KIND_NEWLINE      = 5'd0;
   localparam logic [4:0] KIND_RPAREN       = 5'd1;
   localparam logic [4:0] KIND_LPAREN       = 5'd2;
   localparam logic [4:0] KIND_ASSIGN       = 5'd3;
   localparam logic [4:0] KIND_PLUS         = 5'd4;
   localparam logic [4:0] KIND_MINUS        = 5'd5;
   localparam logic [4:0] KIND_STAR         = 5'd6;
   localparam logic [4:0] KIND_GT           = 5'd7;
   localparam logic [4:0] KIND_LT           = 5'd8;
   localparam logic [4:0] KIND_COMMA        = 5'd9;
   localparam logic [4:0] KIND_SEMI         = 5'd10;
   localparam logic [4:0] KIND_SLASH        = 5'd11;
   localparam logic [4:0] KIND_SHR          = 5'd12;
   localparam logic [4:0] KIND_SHL          = 5'd13;
   localparam logic [4:0] KIND_SHR3         = 5'd14;
   localparam logic [4:0] KIND_SHL3         = 5'd15;
   localparam logic [4:0] KIND_IDENT        = 5'd16;
   localparam logic [4:0] KIND_INT          = 5'd17;
   localparam logic [4:0] KIND_FLOAT        = 5'd18;
   localparam logic [4:0] KIND_KEYWORD_BASE = 5'd19;
   localparam logic [4:0] KIND_END          = 5'd25;
   localparam logic [4:0] KIND_ERROR        = 5'd26;

   // Character codes the lexer reacts to.
   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_LT      = 8'h3C;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_GT      = 8'h3E;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_LOWER_E = 8'h65;

   // Keywords are left-justified, first character in the top byte.
   localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_TABLE] = '{
      {"define", 16'h0},
      {"input", 24'h0},
      {"csd", 40'h0},
      "truncate",
      "saturate",
      {"reg", 40'h0}
   };
   localparam logic [3:0] KW_LEN [KW_TABLE] = '{4'd6, 4'd5, 4'd3, 4'd8, 4'd8, 4'd3};

   typedef enum logic [3:0] {
      MODE_BEGIN,
      MODE_COMMENT,
      MODE_MINUS,
      MODE_GT,
      MODE_GT2,
      MODE_LT,
      MODE_LT2,
      MODE_IDENT,
      MODE_INT,
      MODE_FLOAT,
      MODE_EXP,
      MODE_EXPDIG,
      MODE_ERROR
   } lex_mode_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [15:0] start_offset;
      logic [15:0] token_length;
      logic        last_of_run;
   } token_type;

   typedef struct packed {
      logic not_empty;
      logic has_room;
   } queue_status_type;

   function automatic logic [7:0] kw_char(input int unsigned idx, input logic [2:0] pos);
      return KW_TEXT[idx][(KW_MAX_LEN*8-1) - 8*pos -: 8];
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
   endfunction

endpackage

@@ rtl/dsl_channels.sv @@
// Valid/ready channel interfaces for input bytes and token records.
interface dsl_req_if;
   import dsl_pkg::*;

   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink (input valid, input char_code, output ready);
endinterface

interface dsl_rsp_if;
   import dsl_pkg::*;

   logic        valid;
   logic        ready;
   logic [4:0]  token_kind;
   logic [15:0] start_offset;
   logic [15:0] token_length;
   logic        last_of_run;

   modport source (output valid, output token_kind, output start_offset,
                   output token_length, output last_of_run, input ready);
   modport sink (input valid, input token_kind, input start_offset,
                 input token_length, input last_of_run, output ready);
endinterface

@@ rtl/dsl_lex_core.sv @@
// Lexer state machine: state registers and the per-byte token decision.
module dsl_lex_core #(
   parameter int OFFSET_BITS = dsl_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [7:0]                  char_code,
   output dsl_pkg::token_type [1:0]    tokens,
   output logic [1:0]                  token_count
);
   import dsl_pkg::*;

   typedef struct packed {
      logic         emit;
      logic [4:0]   kind;
      logic         length;
      lex_mode_type mode;
      logic         load;
      logic         load_hits;
      logic [5:0]   hits;
      logic         restart;
   } begin_type;

   lex_mode_type           mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] byte_offset_ff, byte_offset_in;
   logic [OFFSET_BITS-1:0] token_start_ff, token_start_in;
   logic [15:0]            token_bytes_ff, token_bytes_in;
   logic [5:0]             keyword_hits_ff, keyword_hits_in;

   logic                   pre_valid;
   logic [4:0]             pre_kind;
   logic [15:0]            pre_length;
   logic                   do_begin;
   logic                   restart;
   logic [15:0]            bumped;
   begin_type              br;
   logic [OFFSET_BITS+15:0] pos_ext, start_ext;
   token_type              pre_tok, br_tok;

   function automatic logic [5:0] hits_step(input logic [5:0] hits, input logic [15:0] p,
                                            input logic [7:0] c);
      logic [5:0] h;
      h = hits;
      for (int i = 0; i < KW_TABLE; i++) begin
         if (!((p < {12'b0, KW_LEN[i]}) && (kw_char(i, p[2:0]) == c))) begin
            h[i] = 1'b0;
         end
      end
      return h;
   endfunction

   function automatic logic [4:0] ident_kind(input logic [5:0] hits, input logic [15:0] len);
      logic [4:0] kind;
      kind = KIND_IDENT;
      // Walk downward so that the lowest matching keyword wins.
      for (int i = KW_TABLE - 1; i >= 0; i--) begin
         if ((i < KEYWORD_COUNT) && hits[i] && (len == {12'b0, KW_LEN[i]})) begin
            kind = KIND_KEYWORD_BASE + 5'(i);
         end
      end
      return kind;
   endfunction

   function automatic begin_type begin_f(input logic [7:0] c);
      begin_type r;
      r = '0;
      r.mode = MODE_BEGIN;
      r.hits = 6'h3F;
      r.length = 1'b1;
      unique case (c)
         CH_NUL: begin
            r.emit = 1'b1; r.kind = KIND_END; r.length = 1'b0; r.restart = 1'b1;
         end
         CH_SPACE, CH_TAB, CH_CR: begin
         end
         CH_PERCENT: r.mode = MODE_COMMENT;
         CH_LF:      begin r.emit = 1'b1; r.kind = KIND_NEWLINE; end
         CH_RPAREN:  begin r.emit = 1'b1; r.kind = KIND_RPAREN; end
         CH_LPAREN:  begin r.emit = 1'b1; r.kind = KIND_LPAREN; end
         CH_EQUAL:   begin r.emit = 1'b1; r.kind = KIND_ASSIGN; end
         CH_PLUS:    begin r.emit = 1'b1; r.kind = KIND_PLUS; end
         CH_STAR:    begin r.emit = 1'b1; r.kind = KIND_STAR; end
         CH_COMMA:   begin r.emit = 1'b1; r.kind = KIND_COMMA; end
         CH_SEMI:    begin r.emit = 1'b1; r.kind = KIND_SEMI; end
         CH_SLASH:   begin r.emit = 1'b1; r.kind = KIND_SLASH; end
         CH_MINUS:   begin r.mode = MODE_MINUS; r.load = 1'b1; end
         CH_GT:      begin r.mode = MODE_GT; r.load = 1'b1; end
         CH_LT:      begin r.mode = MODE_LT; r.load = 1'b1; end
         default: begin
            if (is_alpha(c)) begin
               r.mode = MODE_IDENT;
               r.load = 1'b1;
               r.load_hits = 1'b1;
               r.hits = hits_step(6'h3F, 16'd0, c);
            end else if (is_digit(c)) begin
               r.mode = MODE_INT;
               r.load = 1'b1;
            end else begin
               r.emit = 1'b1;
               r.kind = KIND_ERROR;
               r.mode = MODE_ERROR;
            end
         end
      endcase
      return r;
   endfunction

   always_comb begin
      mode_in         = mode_ff;
      token_start_in  = token_start_ff;
      token_bytes_in  = token_bytes_ff;
      keyword_hits_in = keyword_hits_ff;
      pre_valid       = 1'b0;
      pre_kind        = KIND_ERROR;
      pre_length      = token_bytes_ff;
      do_begin        = 1'b0;
      bumped          = (token_bytes_ff == 16'hFFFF) ? token_bytes_ff : token_bytes_ff + 16'd1;
      br              = begin_f(char_code);

      unique case (mode_ff)
         MODE_COMMENT: begin
            do_begin = (char_code == CH_LF) || (char_code == CH_NUL);
         end
         MODE_MINUS: begin
            if (is_digit(char_code)) begin
               mode_in = MODE_INT; token_bytes_in = 16'd2;
            end else begin
               pre_valid = 1'b1; pre_kind = KIND_MINUS; pre_length = 16'd1; do_begin = 1'b1;
            end
         end
         MODE_GT: begin
            if (char_code == CH_GT) begin
               mode_in = MODE_GT2; token_bytes_in = 16'd2;
            end else begin
               pre_valid = 1'b1; pre_kind = KIND_GT; pre_length = 16'd1; do_begin = 1'b1;
            end
         end
         MODE_GT2: begin
            pre_valid = 1'b1;
            if (char_code == CH_GT) begin
               pre_kind = KIND_SHR3; pre_length = 16'd3; mode_in = MODE_BEGIN;
            end else begin
               pre_kind = KIND_SHR; pre_length = 16'd2; do_begin = 1'b1;
            end
         end
         MODE_LT: begin
            if (char_code == CH_LT) begin
               mode_in = MODE_LT2; token_bytes_in = 16'd2;
            end else begin
               pre_valid = 1'b1; pre_kind = KIND_LT; pre_length = 16'd1; do_begin = 1'b1;
            end
         end
         MODE_LT2: begin
            pre_valid = 1'b1;
            if (char_code == CH_LT) begin
               pre_kind = KIND_SHL3; pre_length = 16'd3; mode_in = MODE_BEGIN;
            end else begin
               pre_kind = KIND_SHL; pre_length = 16'd2; do_begin = 1'b1;
            end
         end
         MODE_IDENT: begin
            if (is_word(char_code)) begin
               keyword_hits_in = hits_step(keyword_hits_ff, token_bytes_ff, char_code);
               token_bytes_in  = bumped;
            end else begin
               pre_valid = 1'b1;
               pre_kind  = ident_kind(keyword_hits_ff, token_bytes_ff);
               do_begin  = 1'b1;
            end
         end
         MODE_INT: begin
            if (is_digit(char_code)) begin
               token_bytes_in = bumped;
            end else if (char_code == CH_DOT) begin
               token_bytes_in = bumped; mode_in = MODE_FLOAT;
            end else begin
               pre_valid = 1'b1; pre_kind = KIND_INT; do_begin = 1'b1;
            end
         end
         MODE_FLOAT: begin
            if (is_digit(char_code)) begin
               token_bytes_in = bumped;
            end else if (char_code == CH_LOWER_E) begin
               token_bytes_in = bumped; mode_in = MODE_EXP;
            end else begin
               pre_valid = 1'b1; pre_kind = KIND_FLOAT; do_begin = 1'b1;
            end
         end
         MODE_EXP: begin
            token_bytes_in = bumped;
            if (is_digit(char_code) || (char_code == CH_MINUS)) begin
               mode_in = MODE_EXPDIG;
            end else begin
               // The error covers the number and the offending byte; byte 0 still ends input.
               pre_valid  = 1'b1;
               pre_kind   = KIND_ERROR;
               pre_length = bumped;
               mode_in    = MODE_ERROR;
               do_begin   = (char_code == CH_NUL);
            end
         end
         MODE_EXPDIG: begin
            if (is_digit(char_code)) begin
               token_bytes_in = bumped;
            end else begin
               pre_valid = 1'b1; pre_kind = KIND_FLOAT; do_begin = 1'b1;
            end
         end
         MODE_ERROR: begin
            do_begin = (char_code == CH_NUL);
         end
         default: begin
            do_begin = 1'b1;
         end
      endcase

      restart = 1'b0;
      if (do_begin) begin
         mode_in = br.mode;
         restart = br.restart;
         if (br.load) begin
            token_start_in = byte_offset_ff;
            token_bytes_in = 16'd1;
         end
         if (br.load_hits) begin
            keyword_hits_in = br.hits;
         end
      end

      byte_offset_in = restart ? '0
                               : byte_offset_ff + {{(OFFSET_BITS-1){1'b0}}, 1'b1};

      pos_ext   = {16'b0, byte_offset_ff};
      start_ext = {16'b0, token_start_ff};

      pre_tok.token_kind   = pre_kind;
      pre_tok.start_offset = start_ext[15:0];
      pre_tok.token_length = pre_length;
      pre_tok.last_of_run  = 1'b0;

      br_tok.token_kind    = br.kind;
      br_tok.start_offset  = pos_ext[15:0];
      br_tok.token_length  = {15'b0, br.length};
      br_tok.last_of_run   = 1'b1;

      token_count = {1'b0, pre_valid} + {1'b0, do_begin & br.emit};
      tokens[1]   = br_tok;
      if (pre_valid) begin
         tokens[0] = pre_tok;
         tokens[0].last_of_run = !(do_begin & br.emit);
      end else begin
         tokens[0] = br_tok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_BEGIN;
         byte_offset_ff  <= '0;
         token_start_ff  <= '0;
         token_bytes_ff  <= '0;
         keyword_hits_ff <= 6'h3F;
      end else if (accept) begin
         mode_ff         <= mode_in;
         byte_offset_ff  <= byte_offset_in;
         token_start_ff  <= token_start_in;
         token_bytes_ff  <= token_bytes_in;
         keyword_hits_ff <= keyword_hits_in;
      end
   end

endmodule

@@ rtl/dsl_rsp_queue.sv @@
// Small token queue that takes up to two records a cycle and hands out one.
module dsl_rsp_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [1:0]                    push_count,
   input  dsl_pkg::token_type [1:0]      push_tokens,
   input  logic                          pop,
   output dsl_pkg::token_type            head,
   output dsl_pkg::queue_status_type     status
);
   import dsl_pkg::*;

   localparam int PTR_BITS   = $clog2(RSP_DEPTH);
   localparam int LEVEL_BITS = $clog2(RSP_DEPTH + 1);

   token_type               entry_ff [RSP_DEPTH];
   logic [PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [LEVEL_BITS-1:0]   level_ff, level_in;
   logic [PTR_BITS-1:0]     wr_next;

   always_comb begin
      wr_next   = wr_ptr_ff + {{(PTR_BITS-1){1'b0}}, 1'b1};
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(push_count);
      rd_ptr_in = rd_ptr_ff + {{(PTR_BITS-1){1'b0}}, pop};
      level_in  = level_ff + LEVEL_BITS'(push_count) - {{(LEVEL_BITS-1){1'b0}}, pop};
      head      = entry_ff[rd_ptr_ff];
      status.not_empty = (level_ff != '0);
      // Room for two records regardless of this cycle's pop.
      status.has_room  = (level_ff <= LEVEL_BITS'(RSP_DEPTH - 2));
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_tokens[0];
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_next] <= push_tokens[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

@@ rtl/dsl_byte_lexer.sv @@
// Top level of the DSL byte lexer: lexer state machine feeding a token queue.
// The lexer takes one text byte per cycle and turns it into zero, one or two token
// records (kind, start offset, length, last-of-run flag); byte 0 ends the input,
// flushes any pending token, emits an end token and restarts the offset at zero.
// Each accepted byte is decided in the same cycle by the state machine, and its
// tokens are written into a four-entry result queue. A new byte is taken whenever
// the queue holds two records or fewer, so with a sink that takes a token every
// cycle the sustained rate is one byte per cycle; a byte that closes one token and
// opens another adds a record and can hold input back when the sink falls behind.
// Tokens leave the queue in order, one per cycle while the sink is ready; each is
// registered in the queue before it can leave.
module dsl_byte_lexer #(
   parameter int OFFSET_BITS = dsl_pkg::OFFSET_BITS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   dsl_req_if.sink   req_chan,
   dsl_rsp_if.source rsp_chan
);
   import dsl_pkg::*;

   logic             accept;
   logic             pop;
   token_type [1:0]  core_tokens;
   logic [1:0]       core_count;
   logic [1:0]       push_count;
   token_type        head;
   queue_status_type q_status;

   assign accept     = req_chan.valid && req_chan.ready;
   assign pop        = rsp_chan.valid && rsp_chan.ready;
   assign push_count = accept ? core_count : 2'd0;

   dsl_lex_core #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .char_code   (req_chan.char_code),
      .tokens      (core_tokens),
      .token_count (core_count)
   );

   dsl_rsp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_count  (push_count),
      .push_tokens (core_tokens),
      .pop         (pop),
      .head        (head),
      .status      (q_status)
   );

   assign req_chan.ready        = q_status.has_room;
   assign rsp_chan.valid        = q_status.not_empty;
   assign rsp_chan.token_kind   = head.token_kind;
   assign rsp_chan.start_offset = head.start_offset;
   assign rsp_chan.token_length = head.token_length;
   assign rsp_chan.last_of_run  = head.last_of_run;

`ifndef NO_ASSERTIONS
   // Byte 0 always produces at least the end token.
   a_end_yields_token: assert property (@(posedge clock) disable iff (reset)
      accept && (req_chan.char_code == CH_NUL) |=> rsp_chan.valid)
      else $error("end of input produced no token");

   // Any accepted token shows up in the queue on the next cycle.
   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      push_count != 2'd0 |=> q_status.not_empty)
      else $error("pushed token missing from queue");

   // An end token is empty and always closes its byte's run.
   a_end_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.token_kind == KIND_END) |->
         (rsp_chan.token_length == 16'd0) && rsp_chan.last_of_run)
      else $error("malformed end token");
`endif

endmodule

@@ verif/dsl_byte_lexer_checker.sv @@
// Checker that predicts the lexer's token records and compares them with the output channel.
module dsl_byte_lexer_checker (
   input  logic clock,
   input  logic reset,
   dsl_req_if   req_mon,
   dsl_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import dsl_pkg::*;

   lex_mode_type mode;
   logic [15:0]  byte_pos;
   logic [15:0]  tok_start;
   logic [15:0]  tok_len;
   logic [5:0]   kw_hits;
   logic         restart_pos;
   token_type    byte_tokens[$];
   token_type    expected_tokens[$];
   int           errors = 0;

   function automatic logic char_is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic char_is_letter(input logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
   endfunction

   function automatic logic char_is_word(input logic [7:0] c);
      return char_is_letter(c) || char_is_digit(c) || (c == CH_UNDER);
   endfunction

   task automatic add_token(input logic [4:0] kind, input logic [15:0] start,
                            input logic [15:0] len);
      token_type tok;
      tok.token_kind   = kind;
      tok.start_offset = start;
      tok.token_length = len;
      tok.last_of_run  = 1'b0;
      byte_tokens = {byte_tokens, tok};
   endtask

   task automatic grow_token();
      if (tok_len != 16'hFFFF) tok_len = tok_len + 16'd1;
   endtask

   task automatic end_input(input logic [15:0] pos);
      add_token(KIND_END, pos, 16'd0);
      mode = MODE_BEGIN;
      restart_pos = 1'b1;
   endtask

   task automatic open_token(input lex_mode_type next_mode, input logic [15:0] pos);
      mode = next_mode;
      tok_start = pos;
      tok_len = 16'd1;
   endtask

   // Drops every keyword that is too short for position p or whose character there differs from c.
   task automatic narrow_keywords(input logic [7:0] c, input logic [15:0] p);
      int bit_hi;
      bit_hi = KW_MAX_LEN * 8 - 1 - 8 * int'(p);
      for (int i = 0; i < KW_TABLE; i++) begin
         if (p >= 16'(KW_LEN[i])) kw_hits[i] = 1'b0;
         else if (KW_TEXT[i][bit_hi -: 8] != c) kw_hits[i] = 1'b0;
      end
   endtask

   function automatic logic [4:0] word_kind();
      for (int i = 0; i < KEYWORD_COUNT && i < KW_TABLE; i++) begin
         if (kw_hits[i] && tok_len == 16'(KW_LEN[i])) return KIND_KEYWORD_BASE + 5'(i);
      end
      return KIND_IDENT;
   endfunction

   // Lexes a byte as the first byte of a new token.
   task automatic scan_fresh(input logic [7:0] c, input logic [15:0] pos);
      mode = MODE_BEGIN;
      case (c)
         CH_NUL:                  end_input(pos);
         CH_SPACE, CH_TAB, CH_CR: ;
         CH_PERCENT:              mode = MODE_COMMENT;
         CH_LF:                   add_token(KIND_NEWLINE, pos, 16'd1);
         CH_RPAREN:               add_token(KIND_RPAREN, pos, 16'd1);
         CH_LPAREN:               add_token(KIND_LPAREN, pos, 16'd1);
         CH_EQUAL:                add_token(KIND_ASSIGN, pos, 16'd1);
         CH_PLUS:                 add_token(KIND_PLUS, pos, 16'd1);
         CH_STAR:                 add_token(KIND_STAR, pos, 16'd1);
         CH_COMMA:                add_token(KIND_COMMA, pos, 16'd1);
         CH_SEMI:                 add_token(KIND_SEMI, pos, 16'd1);
         CH_SLASH:                add_token(KIND_SLASH, pos, 16'd1);
         CH_MINUS:                open_token(MODE_MINUS, pos);
         CH_GT:                   open_token(MODE_GT, pos);
         CH_LT:                   open_token(MODE_LT, pos);
         default: begin
            if (char_is_letter(c)) begin
               open_token(MODE_IDENT, pos);
               kw_hits = '1;
               narrow_keywords(c, 16'd0);
            end else if (char_is_digit(c)) begin
               open_token(MODE_INT, pos);
            end else begin
               add_token(KIND_ERROR, pos, 16'd1);
               mode = MODE_ERROR;
            end
         end
      endcase
   endtask

   task automatic lex_byte(input logic [7:0] c);
      logic [15:0] pos;
      pos = byte_pos;
      restart_pos = 1'b0;
      byte_tokens.delete();
      case (mode)
         MODE_COMMENT: begin
            if (c == CH_LF || c == CH_NUL) scan_fresh(c, pos);
         end
         MODE_MINUS: begin
            if (char_is_digit(c)) begin
               mode = MODE_INT;
               tok_len = 16'd2;
            end else begin
               add_token(KIND_MINUS, tok_start, 16'd1);
               scan_fresh(c, pos);
            end
         end
         MODE_GT: begin
            if (c == CH_GT) begin
               mode = MODE_GT2;
               tok_len = 16'd2;
            end else begin
               add_token(KIND_GT, tok_start, 16'd1);
               scan_fresh(c, pos);
            end
         end
         MODE_GT2: begin
            if (c == CH_GT) begin
               add_token(KIND_SHR3, tok_start, 16'd3);
               mode = MODE_BEGIN;
            end else begin
               add_token(KIND_SHR, tok_start, 16'd2);
               scan_fresh(c, pos);
            end
         end
         MODE_LT: begin
            if (c == CH_LT) begin
               mode = MODE_LT2;
               tok_len = 16'd2;
            end else begin
               add_token(KIND_LT, tok_start, 16'd1);
               scan_fresh(c, pos);
            end
         end
         MODE_LT2: begin
            if (c == CH_LT) begin
               add_token(KIND_SHL3, tok_start, 16'd3);
               mode = MODE_BEGIN;
            end else begin
               add_token(KIND_SHL, tok_start, 16'd2);
               scan_fresh(c, pos);
            end
         end
         MODE_IDENT: begin
            if (char_is_word(c)) begin
               narrow_keywords(c, tok_len);
               grow_token();
            end else begin
               add_token(word_kind(), tok_start, tok_len);
               scan_fresh(c, pos);
            end
         end
         MODE_INT: begin
            if (char_is_digit(c)) begin
               grow_token();
            end else if (c == CH_DOT) begin
               grow_token();
               mode = MODE_FLOAT;
            end else begin
               add_token(KIND_INT, tok_start, tok_len);
               scan_fresh(c, pos);
            end
         end
         MODE_FLOAT: begin
            if (char_is_digit(c)) begin
               grow_token();
            end else if (c == CH_LOWER_E) begin
               grow_token();
               mode = MODE_EXP;
            end else begin
               add_token(KIND_FLOAT, tok_start, tok_len);
               scan_fresh(c, pos);
            end
         end
         MODE_EXP: begin
            grow_token();
            if (char_is_digit(c) || c == CH_MINUS) begin
               mode = MODE_EXPDIG;
            end else begin
               // The error token spans the whole number, the offending byte included.
               add_token(KIND_ERROR, tok_start, tok_len);
               if (c == CH_NUL) end_input(pos);
               else mode = MODE_ERROR;
            end
         end
         MODE_EXPDIG: begin
            if (char_is_digit(c)) begin
               grow_token();
            end else begin
               add_token(KIND_FLOAT, tok_start, tok_len);
               scan_fresh(c, pos);
            end
         end
         MODE_ERROR: begin
            if (c == CH_NUL) end_input(pos);
         end
         default: scan_fresh(c, pos);
      endcase
      if (byte_tokens.size() != 0) byte_tokens[byte_tokens.size() - 1].last_of_run = 1'b1;
      expected_tokens = {expected_tokens, byte_tokens};
      byte_pos = restart_pos ? 16'd0 : byte_pos + 16'd1;
   endtask

   always @(posedge clock) begin
      token_type want;
      if (reset) begin
         mode = MODE_BEGIN;
         byte_pos = '0;
         tok_start = '0;
         tok_len = '0;
         kw_hits = '1;
         expected_tokens.delete();
      end else begin
         // A byte's tokens leave no sooner than the cycle after its transaction,
         // so predicting first never changes what is compared here.
         if (req_mon.valid && req_mon.ready) lex_byte(req_mon.char_code);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_tokens.size() == 0) begin
               $error("unexpected token: kind %0d, offset %0d, length %0d",
                      rsp_mon.token_kind, rsp_mon.start_offset, rsp_mon.token_length);
               errors++;
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_mon.token_kind !== want.token_kind) begin
                  $error("token_kind: expected %0d, actual %0d",
                         want.token_kind, rsp_mon.token_kind);
                  errors++;
               end
               if (rsp_mon.start_offset !== want.start_offset) begin
                  $error("start_offset: expected %0d, actual %0d",
                         want.start_offset, rsp_mon.start_offset);
                  errors++;
               end
               if (rsp_mon.token_length !== want.token_length) begin
                  $error("token_length: expected %0d, actual %0d",
                         want.token_length, rsp_mon.token_length);
                  errors++;
               end
               if (rsp_mon.last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %0d, actual %0d",
                         want.last_of_run, rsp_mon.last_of_run);
                  errors++;
               end
            end
         end
      end
      fail_count <= errors;
      pending_count <= expected_tokens.size();
   end

endmodule

@@ verif/dsl_byte_lexer_tb.sv @@
// Testbench top of the DSL byte lexer: clock, reset, byte stimulus, output pacing and verdict.
module dsl_byte_lexer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dsl_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1600;
   localparam int HOLD_CYCLES  = 300;
   localparam int LONG_WORD    = 64;
   localparam int DRAIN_CYCLES = 20;

   logic       clock;
   logic       reset;
   logic       idle_on = 1'b1;
   logic       stall_on = 1'b1;
   logic       want_hold = 1'b0;
   int         cycles = 0;
   int         sent = 0;
   int         fail_count;
   int         pending_count;
   logic [7:0] text_q[$];
   string      keyword_words[6] = '{"define", "input", "csd", "truncate", "saturate", "reg"};
   string      punct_chars = ")(=+*,;/-><";

   dsl_req_if req_chan ();
   dsl_rsp_if rsp_chan ();

   dsl_byte_lexer uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   dsl_byte_lexer_checker token_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("dsl_byte_lexer_tb failed");
         $finish;
      end
   end

   function automatic logic [7:0] rand_digit();
      return 8'h30 + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] rand_letter();
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] rand_word_char();
      case ($urandom_range(0, 7))
         0:       return rand_digit();
         1:       return CH_UNDER;
         default: return rand_letter();
      endcase
   endfunction

   task automatic queue_byte(input logic [7:0] c);
      text_q = {text_q, c};
   endtask

   task automatic push_str(input string s);
      for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
   endtask

   task automatic send_byte(input logic [7:0] c);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.char_code <= c;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic send_text();
      while (text_q.size() != 0) begin
         send_byte(text_q.pop_front());
         sent++;
      end
   endtask

   // One line of source text, ended by byte 0. Broken input ends the line at once,
   // so that the bytes the lexer would ignore stay few.
   task automatic build_sentence();
      int         parts;
      string      word;
      logic [7:0] sym;
      parts = $urandom_range(1, 8);
      for (int p = 0; p < parts; p++) begin
         case ($urandom_range(0, 19))
            0, 1, 2: begin
               word = keyword_words[$urandom_range(0, 5)];
               if ($urandom_range(0, 5) == 0) word = word.substr(0, word.len() - 2);
               push_str(word);
               if ($urandom_range(0, 5) == 0) queue_byte(rand_word_char());
            end
            3, 4, 5: begin
               queue_byte(rand_letter());
               repeat ($urandom_range(0, 9)) queue_byte(rand_word_char());
            end
            6, 7, 8: begin
               if ($urandom_range(0, 2) == 0) queue_byte(CH_MINUS);
               repeat ($urandom_range(1, 5)) queue_byte(rand_digit());
            end
            9, 10: begin
               repeat ($urandom_range(1, 3)) queue_byte(rand_digit());
               queue_byte(CH_DOT);
               repeat ($urandom_range(0, 3)) queue_byte(rand_digit());
               if ($urandom_range(0, 1) == 1) begin
                  queue_byte(CH_LOWER_E);
                  if ($urandom_range(0, 1) == 1) queue_byte(CH_MINUS);
                  repeat ($urandom_range(1, 3)) queue_byte(rand_digit());
               end
            end
            11, 12, 13: queue_byte(punct_chars[$urandom_range(0, punct_chars.len() - 1)]);
            14: begin
               sym = $urandom_range(0, 1) ? CH_GT : CH_LT;
               repeat ($urandom_range(1, 4)) queue_byte(sym);
            end
            15: queue_byte(CH_LF);
            16: begin
               queue_byte(CH_PERCENT);
               repeat ($urandom_range(0, 6)) begin
                  sym = 8'($urandom_range(1, 255));
                  queue_byte(sym == CH_LF ? CH_CR : sym);
               end
               if ($urandom_range(0, 2) != 0) queue_byte(CH_LF);
            end
            17: repeat ($urandom_range(1, 3)) queue_byte(CH_SPACE);
            18: begin
               queue_byte(8'($urandom_range(1, 255)));
               break;
            end
            default: begin
               // A number whose exponent marker is followed by an arbitrary byte.
               repeat ($urandom_range(1, 3)) queue_byte(rand_digit());
               queue_byte(CH_DOT);
               queue_byte(CH_LOWER_E);
               queue_byte(8'($urandom_range(1, 255)));
               break;
            end
         endcase
         case ($urandom_range(0, 5))
            0:       queue_byte(CH_SPACE);
            1:       queue_byte(CH_TAB);
            2:       queue_byte(CH_CR);
            default: ;
         endcase
      end
      queue_byte(CH_NUL);
   endtask

   // Output side: random stalls, plus one long hold that backs the lexer up into its input.
   initial begin
      rsp_chan.ready = 1'b1;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (want_hold) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            want_hold = 1'b0;
         end else if (stall_on && $urandom_range(0, 7) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.char_code = 8'h00;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed text: a keyword closed by a bracket, shift operators, a bad exponent
      // ended by a letter and by byte 0, unknown bytes and a comment.
      push_str("reg(>>><<-9.ex");
      queue_byte(CH_NUL);
      queue_byte(8'hFF);
      queue_byte(8'h01);
      queue_byte(CH_NUL);
      push_str("1.e");
      queue_byte(CH_NUL);
      push_str("%z\n");
      queue_byte(CH_NUL);
      send_text();

      sent = 0;
      want_hold = 1'b1;
      while (sent < RANDOM_ITEMS) begin
         build_sentence();
         send_text();
      end

      // A long word and a few tokens sent with no idling on either side.
      idle_on = 1'b0;
      stall_on = 1'b0;
      queue_byte(rand_letter());
      for (int i = 1; i < LONG_WORD; i++) queue_byte(rand_word_char());
      push_str(" 42 >>> reg\n");
      queue_byte(CH_NUL);
      send_text();

      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("dsl_byte_lexer_tb passed");
      end else begin
         $display("dsl_byte_lexer_tb failed");
      end
      $finish;
   end

endmodule
